// ===== sv/cau_pkg.sv =====
// Shared types and constants for the complex arithmetic unit.
// No dependencies; imported by every module of the block.
package cau_pkg;

	localparam int FIELD_W  = 16;  // input field width (Q8.8)
	localparam int IN_FRAC  = 8;
	localparam int OUT_FRAC = 16;
	localparam int RES_W    = 32;  // result part width (Q16.16)
	localparam int QUO_W    = 2 * OUT_FRAC;
	localparam int OP_W     = 2;
	localparam int ST_W     = 2;

	typedef enum logic [OP_W-1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK  = 2'd0,
		ST_SAT = 2'd1,
		ST_DZ  = 2'd2
	} status_t;

	typedef struct packed {
		logic is_div;
		logic dz;
		logic neg_re;
		logic neg_im;
		logic ovf_re;
		logic ovf_im;
	} ctrl_t;

endpackage

// ===== sv/cau_mult.sv =====
// Stage 1: operand extension, add/sub sums and the six partial products.
// Depends on cau_pkg.
module cau_mult #(
	parameter int EW = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  cau_pkg::op_t                 op,
	input  logic [cau_pkg::FIELD_W-1:0]  a_real,
	input  logic [cau_pkg::FIELD_W-1:0]  a_imag,
	input  logic [cau_pkg::FIELD_W-1:0]  b_real,
	input  logic [cau_pkg::FIELD_W-1:0]  b_imag,
	output logic                         out_valid,
	input  logic                         out_ready,
	output cau_pkg::op_t                 op_s1,
	output logic signed [EW:0]           sre_s1,
	output logic signed [EW:0]           sim_s1,
	output logic signed [2*EW-1:0]       rr_s1,
	output logic signed [2*EW-1:0]       ii_s1,
	output logic signed [2*EW-1:0]       ri_s1,
	output logic signed [2*EW-1:0]       ir_s1,
	output logic signed [2*EW-1:0]       br2_s1,
	output logic signed [2*EW-1:0]       bi2_s1
);
	import cau_pkg::*;

	localparam int AW = EW + 1;

	logic signed [EW-1:0] ar, ai, br, bi;
	logic signed [AW-1:0] sre, sim;
	logic                 v_s1;

	// narrower operands keep the low bits as signed; a wider one is the field zero-extended
	assign ar = $signed(EW'(a_real));
	assign ai = $signed(EW'(a_imag));
	assign br = $signed(EW'(b_real));
	assign bi = $signed(EW'(b_imag));

	always_comb begin
		if (op == OP_SUB) begin
			sre = AW'(ar) - AW'(br);
			sim = AW'(ai) - AW'(bi);
		end else begin
			sre = AW'(ar) + AW'(br);
			sim = AW'(ai) + AW'(bi);
		end
	end

	assign in_ready  = !v_s1 || out_ready;
	assign out_valid = v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1  <= op;
			sre_s1 <= sre;
			sim_s1 <= sim;
			rr_s1  <= ar * br;
			ii_s1  <= ai * bi;
			ri_s1  <= ar * bi;
			ir_s1  <= ai * br;
			br2_s1 <= br * br;
			bi2_s1 <= bi * bi;
		end
	end

endmodule

// ===== sv/cau_comb.sv =====
// Stage 2: combines the add/sub sums or the partial products per operation
// into sign and magnitude, and forms the divisor. Depends on cau_pkg.
module cau_comb #(
	parameter int EW = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  cau_pkg::op_t            op,
	input  logic signed [EW:0]      sre,
	input  logic signed [EW:0]      sim,
	input  logic signed [2*EW-1:0]  rr,
	input  logic signed [2*EW-1:0]  ii,
	input  logic signed [2*EW-1:0]  ri,
	input  logic signed [2*EW-1:0]  ir,
	input  logic signed [2*EW-1:0]  br2,
	input  logic signed [2*EW-1:0]  bi2,
	output logic                    out_valid,
	input  logic                    out_ready,
	output cau_pkg::ctrl_t          ctrl_s2,
	output logic [2*EW:0]           mre_s2,
	output logic [2*EW:0]           mim_s2,
	output logic [2*EW-1:0]         den_s2
);
	import cau_pkg::*;

	localparam int SW = 2 * EW + 1;
	localparam int DW = 2 * EW;
	localparam int FS = OUT_FRAC - IN_FRAC;

	logic signed [SW-1:0] vre, vim;
	logic [SW-1:0]        mre, mim;
	logic [DW-1:0]        den;
	ctrl_t                ctrl;
	logic                 v_s2;

	always_comb begin
		vre = '0;
		vim = '0;
		case (op)
			OP_ADD, OP_SUB: begin
				vre = SW'(sre) <<< FS;
				vim = SW'(sim) <<< FS;
			end
			OP_MUL: begin
				vre = SW'(rr) - SW'(ii);
				vim = SW'(ri) + SW'(ir);
			end
			OP_DIV: begin
				vre = SW'(rr) + SW'(ii);
				vim = SW'(ir) - SW'(ri);
			end
			default: begin
				vre = '0;
				vim = '0;
			end
		endcase
	end

	assign mre = vre[SW-1] ? $unsigned(-vre) : $unsigned(vre);
	assign mim = vim[SW-1] ? $unsigned(-vim) : $unsigned(vim);
	// squares are non-negative; their sum fits DW bits
	assign den = $unsigned(br2) + $unsigned(bi2);

	always_comb begin
		ctrl        = '0;
		ctrl.is_div = (op == OP_DIV);
		ctrl.dz     = (op == OP_DIV) && (den == '0);
		ctrl.neg_re = vre[SW-1];
		ctrl.neg_im = vim[SW-1];
	end

	assign in_ready  = !v_s2 || out_ready;
	assign out_valid = v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (in_ready) begin
			v_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ctrl_s2 <= ctrl;
			mre_s2  <= mre;
			mim_s2  <= mim;
			den_s2  <= den;
		end
	end

endmodule

// ===== sv/cau_div.sv =====
// Stage 3: pipelined restoring divider, one quotient bit per stage for both parts,
// computing floor(mag * 2^16 / den). Non-divide beats ride along. Depends on cau_pkg.
module cau_div #(
	parameter int EW = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  cau_pkg::ctrl_t              ctrl,
	input  logic [2*EW:0]               mre,
	input  logic [2*EW:0]               mim,
	input  logic [2*EW-1:0]             den,
	output logic                        out_valid,
	input  logic                        out_ready,
	output cau_pkg::ctrl_t              out_ctrl,
	output logic [2*EW:0]               out_mre,
	output logic [2*EW:0]               out_mim,
	output logic [cau_pkg::QUO_W-1:0]   out_qre,
	output logic [cau_pkg::QUO_W-1:0]   out_qim
);
	import cau_pkg::*;

	localparam int SW = 2 * EW + 1;
	localparam int DW = 2 * EW;
	localparam int NS = QUO_W;

	logic              v_s3    [0:NS];
	ctrl_t             ctrl_s3 [0:NS];
	logic [SW-1:0]     pre_s3  [0:NS];
	logic [SW-1:0]     pim_s3  [0:NS];
	logic [DW-1:0]     den_s3  [0:NS];
	logic [DW-1:0]     rre_s3  [0:NS];
	logic [DW-1:0]     rim_s3  [0:NS];
	logic [QUO_W-1:0]  qre_s3  [0:NS];
	logic [QUO_W-1:0]  qim_s3  [0:NS];

	logic [DW-1:0]     nrre [1:NS];
	logic [DW-1:0]     nrim [1:NS];
	logic [QUO_W-1:0]  nqre [1:NS];
	logic [QUO_W-1:0]  nqim [1:NS];

	logic [SW-1:0]     hre, him;
	ctrl_t             ctrl0;
	logic              en;

	// integer part of mag / 2^16 seeds the remainder; quotient overflows when it reaches den
	assign hre = mre >> OUT_FRAC;
	assign him = mim >> OUT_FRAC;

	always_comb begin
		ctrl0        = ctrl;
		ctrl0.ovf_re = ctrl.is_div && (hre >= SW'(den));
		ctrl0.ovf_im = ctrl.is_div && (him >= SW'(den));
	end

	for (genvar k = 1; k <= NS; k++) begin : g_step
		logic [DW:0] tre, tim;
		logic        gre, gim;

		// shift register feeds the remaining dividend bits at the top, quotient in at the bottom
		assign tre     = {rre_s3[k-1], qre_s3[k-1][QUO_W-1]};
		assign tim     = {rim_s3[k-1], qim_s3[k-1][QUO_W-1]};
		assign gre     = tre >= {1'b0, den_s3[k-1]};
		assign gim     = tim >= {1'b0, den_s3[k-1]};
		assign nrre[k] = gre ? DW'(tre - {1'b0, den_s3[k-1]}) : DW'(tre);
		assign nrim[k] = gim ? DW'(tim - {1'b0, den_s3[k-1]}) : DW'(tim);
		assign nqre[k] = {qre_s3[k-1][QUO_W-2:0], gre};
		assign nqim[k] = {qim_s3[k-1][QUO_W-2:0], gim};
	end

	assign en        = !v_s3[NS] || out_ready;
	assign in_ready  = en;
	assign out_valid = v_s3[NS];
	assign out_ctrl  = ctrl_s3[NS];
	assign out_mre   = pre_s3[NS];
	assign out_mim   = pim_s3[NS];
	assign out_qre   = qre_s3[NS];
	assign out_qim   = qim_s3[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NS; k++) begin
				v_s3[k] <= 1'b0;
			end
		end else if (en) begin
			v_s3[0] <= in_valid;
			for (int k = 1; k <= NS; k++) begin
				v_s3[k] <= v_s3[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctrl_s3[0] <= ctrl0;
			pre_s3[0]  <= mre;
			pim_s3[0]  <= mim;
			den_s3[0]  <= den;
			rre_s3[0]  <= DW'(hre);
			rim_s3[0]  <= DW'(him);
			qre_s3[0]  <= QUO_W'({mre[OUT_FRAC-1:0], OUT_FRAC'(0)});
			qim_s3[0]  <= QUO_W'({mim[OUT_FRAC-1:0], OUT_FRAC'(0)});
			for (int k = 1; k <= NS; k++) begin
				ctrl_s3[k] <= ctrl_s3[k-1];
				pre_s3[k]  <= pre_s3[k-1];
				pim_s3[k]  <= pim_s3[k-1];
				den_s3[k]  <= den_s3[k-1];
				rre_s3[k]  <= nrre[k];
				rim_s3[k]  <= nrim[k];
				qre_s3[k]  <= nqre[k];
				qim_s3[k]  <= nqim[k];
			end
		end
	end

endmodule

// ===== sv/cau_sat.sv =====
// Stage 4: result select, sign restore, saturation and status; holds the output register.
// Depends on cau_pkg.
module cau_sat #(
	parameter int EW = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  cau_pkg::ctrl_t                     ctrl,
	input  logic [2*EW:0]                      mre,
	input  logic [2*EW:0]                      mim,
	input  logic [cau_pkg::QUO_W-1:0]          qre,
	input  logic [cau_pkg::QUO_W-1:0]          qim,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [cau_pkg::RES_W-1:0]   res_real_s4,
	output logic signed [cau_pkg::RES_W-1:0]   res_imag_s4,
	output cau_pkg::status_t                   status_s4
);
	import cau_pkg::*;

	localparam int SW = 2 * EW + 1;
	localparam int MW = (SW > QUO_W + 1) ? SW : QUO_W + 1;

	logic [MW-1:0]    mag_re, mag_im;
	logic [RES_W:0]   cre, cim;
	logic [RES_W-1:0] res_re, res_im;
	status_t          status;
	logic             v_s4;

	// returns {saturated, value}
	function automatic logic [RES_W:0] clamp(input logic neg, input logic force_sat,
			input logic [MW-1:0] mag);
		logic [MW-1:0]    lim;
		logic             sat;
		logic [RES_W-1:0] val;
		lim = MW'(1) << (RES_W - 1);
		sat = force_sat || (neg ? (mag > lim) : (mag >= lim));
		if (sat) begin
			val = neg ? {1'b1, {(RES_W-1){1'b0}}} : {1'b0, {(RES_W-1){1'b1}}};
		end else begin
			val = neg ? RES_W'(-mag) : RES_W'(mag);
		end
		return {sat, val};
	endfunction

	assign mag_re = ctrl.is_div ? MW'(qre) : MW'(mre);
	assign mag_im = ctrl.is_div ? MW'(qim) : MW'(mim);
	assign cre    = clamp(ctrl.neg_re, ctrl.is_div && ctrl.ovf_re, mag_re);
	assign cim    = clamp(ctrl.neg_im, ctrl.is_div && ctrl.ovf_im, mag_im);

	always_comb begin
		if (ctrl.dz) begin
			res_re = '0;
			res_im = '0;
			status = ST_DZ;
		end else begin
			res_re = cre[RES_W-1:0];
			res_im = cim[RES_W-1:0];
			status = (cre[RES_W] || cim[RES_W]) ? ST_SAT : ST_OK;
		end
	end

	assign in_ready  = !v_s4 || out_ready;
	assign out_valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (in_ready) begin
			v_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			res_real_s4 <= $signed(res_re);
			res_imag_s4 <= $signed(res_im);
			status_s4   <= status;
		end
	end

endmodule

// ===== sv/complex_arithmetic_unit.sv =====
// Complex add/sub/mul/div, Q8.8 operands in, saturated Q16.16 parts out.
// Pipeline: multiply, combine, 33 divider stages (seed + 32 quotient bits), output.
// One beat per cycle for every operation while not stalled; 32 quotient bits set the depth.
// A stall at the output holds the whole divider; input is taken whenever stage 1 can move.
// arst_n clears all valid bits at once; data registers are not reset.
// Depends on cau_pkg, cau_mult, cau_comb, cau_div, cau_sat.
module complex_arithmetic_unit #(
	parameter int OPERAND_WIDTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [4*cau_pkg::FIELD_W-1:0]    s_tdata,   // a_real, a_imag, b_real, b_imag
	input  logic [cau_pkg::OP_W-1:0]         s_tuser,   // operation
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [2*cau_pkg::RES_W-1:0]      m_tdata,   // res_real, res_imag
	output logic [cau_pkg::ST_W-1:0]         m_tuser    // status
);
	import cau_pkg::*;

	// operands wider than the field carry only non-negative values
	localparam int EW = (OPERAND_WIDTH > FIELD_W) ? FIELD_W + 1 : OPERAND_WIDTH;
	localparam int SW = 2 * EW + 1;
	localparam int DW = 2 * EW;

	// stage 1 -> 2
	logic                 v1, r2;
	op_t                  op_s1;
	logic signed [EW:0]   sre_s1, sim_s1;
	logic signed [DW-1:0] rr_s1, ii_s1, ri_s1, ir_s1, br2_s1, bi2_s1;

	// stage 2 -> 3
	logic                 v2, r3;
	ctrl_t                ctrl_s2;
	logic [SW-1:0]        mre_s2, mim_s2;
	logic [DW-1:0]        den_s2;

	// stage 3 -> 4
	logic                 v3, r4;
	ctrl_t                ctrl_s3;
	logic [SW-1:0]        mre_s3, mim_s3;
	logic [QUO_W-1:0]     qre_s3, qim_s3;

	logic signed [RES_W-1:0] res_real_s4, res_imag_s4;
	status_t                 status_s4;

	cau_mult #(.EW(EW)) u_mult (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.op        (op_t'(s_tuser)),
		.a_real    (s_tdata[FIELD_W-1:0]),
		.a_imag    (s_tdata[2*FIELD_W-1:FIELD_W]),
		.b_real    (s_tdata[3*FIELD_W-1:2*FIELD_W]),
		.b_imag    (s_tdata[4*FIELD_W-1:3*FIELD_W]),
		.out_valid (v1),
		.out_ready (r2),
		.op_s1     (op_s1),
		.sre_s1    (sre_s1),
		.sim_s1    (sim_s1),
		.rr_s1     (rr_s1),
		.ii_s1     (ii_s1),
		.ri_s1     (ri_s1),
		.ir_s1     (ir_s1),
		.br2_s1    (br2_s1),
		.bi2_s1    (bi2_s1)
	);

	cau_comb #(.EW(EW)) u_comb (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v1),
		.in_ready  (r2),
		.op        (op_s1),
		.sre       (sre_s1),
		.sim       (sim_s1),
		.rr        (rr_s1),
		.ii        (ii_s1),
		.ri        (ri_s1),
		.ir        (ir_s1),
		.br2       (br2_s1),
		.bi2       (bi2_s1),
		.out_valid (v2),
		.out_ready (r3),
		.ctrl_s2   (ctrl_s2),
		.mre_s2    (mre_s2),
		.mim_s2    (mim_s2),
		.den_s2    (den_s2)
	);

	cau_div #(.EW(EW)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v2),
		.in_ready  (r3),
		.ctrl      (ctrl_s2),
		.mre       (mre_s2),
		.mim       (mim_s2),
		.den       (den_s2),
		.out_valid (v3),
		.out_ready (r4),
		.out_ctrl  (ctrl_s3),
		.out_mre   (mre_s3),
		.out_mim   (mim_s3),
		.out_qre   (qre_s3),
		.out_qim   (qim_s3)
	);

	cau_sat #(.EW(EW)) u_sat (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (v3),
		.in_ready    (r4),
		.ctrl        (ctrl_s3),
		.mre         (mre_s3),
		.mim         (mim_s3),
		.qre         (qre_s3),
		.qim         (qim_s3),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.res_real_s4 (res_real_s4),
		.res_imag_s4 (res_imag_s4),
		.status_s4   (status_s4)
	);

	assign m_tdata = {res_imag_s4, res_real_s4};
	assign m_tuser = status_s4;

endmodule

// ===== sv/cau_checker.sv =====
// Port-level checks for complex_arithmetic_unit, attached by bind.
// Depends on cau_pkg and the top level's port list.
module cau_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic [4*cau_pkg::FIELD_W-1:0]    s_tdata,
	input logic [cau_pkg::OP_W-1:0]         s_tuser,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [2*cau_pkg::RES_W-1:0]      m_tdata,
	input logic [cau_pkg::ST_W-1:0]         m_tuser
);
	import cau_pkg::*;

	localparam logic [RES_W-1:0] POS_RAIL = {1'b0, {(RES_W-1){1'b1}}};
	localparam logic [RES_W-1:0] NEG_RAIL = {1'b1, {(RES_W-1){1'b0}}};

	logic [RES_W-1:0] re, im;

	assign re = m_tdata[RES_W-1:0];
	assign im = m_tdata[2*RES_W-1:RES_W];

	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("output beat valid during reset");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled output beat changed");

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_DZ) |-> (m_tdata == '0))
		else $error("divide-by-zero beat carries nonzero parts");

	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_SAT) |->
			(re == POS_RAIL) || (re == NEG_RAIL) || (im == POS_RAIL) || (im == NEG_RAIL))
		else $error("saturated beat has no part at a rail");

	// an accepted input beat carries known operands and operation
	a_in_known: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> !$isunknown({s_tuser, s_tdata}))
		else $error("input beat accepted with unknown bits");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);

// ===== bench/testbench.sv =====
// Self-checking bench for complex_arithmetic_unit: add, sub, mul and div on Q8.8 operands.
// Computes every expected Q16.16 result and status, and checks each output beat in order.
// Depends on cau_pkg and the complex_arithmetic_unit RTL only.
module testbench;
	import cau_pkg::*;

	localparam int     WATCHDOG_LIMIT = 2000;  // cycles with no beat on either side
	localparam int     DRAIN_CYCLES   = 40;    // longer than the whole pipeline
	localparam int     REPORT_LIMIT   = 10;
	localparam int     RANDOM_ITEMS   = 260;   // per idling phase
	localparam longint RES_MAX        = (longint'(1) <<< 31) - 1;
	localparam longint RES_MIN        = -(longint'(1) <<< 31);
	localparam longint QUO_CAP        = longint'(1) <<< 32;

	typedef struct {
		logic [RES_W-1:0] re;
		logic [RES_W-1:0] im;
		status_t          st;
	} cplx_res_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [4*FIELD_W-1:0]   s_tdata;
	logic [OP_W-1:0]        s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [2*RES_W-1:0]     m_tdata;
	logic [ST_W-1:0]        m_tuser;

	cplx_res_t pending_results[$];
	cplx_res_t oldest;
	int        mismatches     = 0;
	int        quiet_cycles   = 0;
	int        send_idle_pct  = 0;
	int        recv_stall_pct = 0;

	complex_arithmetic_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [RES_W-1:0] clamp_q16(input longint v, inout bit sat);
		if (v > RES_MAX) begin
			sat = 1'b1;
			return RES_MAX[RES_W-1:0];
		end
		if (v < RES_MIN) begin
			sat = 1'b1;
			return RES_MIN[RES_W-1:0];
		end
		return v[RES_W-1:0];
	endfunction

	// num * 2^16 / den truncated toward zero; magnitude capped at 2^32
	function automatic longint scaled_quotient(input longint num, input longint den);
		longint mag;
		longint q;
		mag = (num < 0) ? -num : num;
		q = (mag <<< OUT_FRAC) / den;
		if (q > QUO_CAP)
			q = QUO_CAP;
		return (num < 0) ? -q : q;
	endfunction

	function automatic cplx_res_t complex_op_result(input op_t op,
			input logic signed [FIELD_W-1:0] ar, ai, br, bi);
		longint    x_r, x_i, y_r, y_i, re, im, den;
		bit        sat;
		cplx_res_t r;
		x_r = ar;
		x_i = ai;
		y_r = br;
		y_i = bi;
		sat = 1'b0;
		case (op)
			OP_ADD: begin
				re = (x_r + y_r) <<< (OUT_FRAC - IN_FRAC);
				im = (x_i + y_i) <<< (OUT_FRAC - IN_FRAC);
			end
			OP_SUB: begin
				re = (x_r - y_r) <<< (OUT_FRAC - IN_FRAC);
				im = (x_i - y_i) <<< (OUT_FRAC - IN_FRAC);
			end
			OP_MUL: begin
				re = x_r * y_r - x_i * y_i;
				im = x_r * y_i + x_i * y_r;
			end
			default: begin
				den = y_r * y_r + y_i * y_i;
				if (den == 0) begin
					r.re = '0;
					r.im = '0;
					r.st = ST_DZ;
					return r;
				end
				re = scaled_quotient(x_r * y_r + x_i * y_i, den);
				im = scaled_quotient(x_i * y_r - x_r * y_i, den);
			end
		endcase
		r.re = clamp_q16(re, sat);
		r.im = clamp_q16(im, sat);
		r.st = sat ? ST_SAT : ST_OK;
		return r;
	endfunction

	// entered at a falling edge; leaves at the falling edge after the beat is taken
	task automatic send_item(input op_t op, input logic [FIELD_W-1:0] ar, ai, br, bi);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = op;
		s_tdata  = {bi, br, ai, ar};
		do
			@(posedge clk);
		while (!s_tready);
		pending_results.push_back(complex_op_result(op, ar, ai, br, bi));
		@(negedge clk);
	endtask

	function automatic logic [FIELD_W-1:0] random_part();
		case ($urandom_range(9))
			0, 1: begin
				case ($urandom_range(4))
					0:       return 16'h8000;
					1:       return 16'h7FFF;
					2:       return 16'h0000;
					3:       return 16'h0001;
					default: return 16'hFFFF;
				endcase
			end
			2, 3:    return FIELD_W'(int'($urandom_range(1023)) - 512);
			default: return FIELD_W'($urandom());
		endcase
	endfunction

	task automatic test_add_sub_limits();
		send_item(OP_ADD, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_item(OP_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_item(OP_SUB, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
		send_item(OP_SUB, 16'h8000, 16'h0000, 16'h7FFF, 16'hFFFF);
		send_item(OP_ADD, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_item(OP_SUB, 16'h0100, 16'hFF00, 16'h0100, 16'hFF00);
	endtask

	task automatic test_multiply_limits();
		// all parts at the minimum push the imaginary sum to +2^31: saturates
		send_item(OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_item(OP_MUL, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_item(OP_MUL, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
		send_item(OP_MUL, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
		send_item(OP_MUL, 16'h0100, 16'h0000, 16'h0100, 16'h0000);
		send_item(OP_MUL, 16'hFFFF, 16'h0001, 16'h0001, 16'hFFFF);
	endtask

	task automatic test_divide_cases();
		// zero divisor
		send_item(OP_DIV, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000);
		send_item(OP_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		// quotient of exactly +2^31 saturates, exactly -2^31 does not
		send_item(OP_DIV, 16'h8000, 16'h0000, 16'hFFFF, 16'h0000);
		send_item(OP_DIV, 16'h8000, 16'h0000, 16'h0001, 16'h0000);
		send_item(OP_DIV, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF);
		send_item(OP_DIV, 16'h7FFF, 16'h8000, 16'h0001, 16'h0000);
		send_item(OP_DIV, 16'h0100, 16'h0000, 16'h0100, 16'h0000);
		// inexact quotients, truncated toward zero on both signs
		send_item(OP_DIV, 16'h0100, 16'h0200, 16'h0300, 16'hFF00);
		send_item(OP_DIV, 16'hFF00, 16'h0000, 16'h0300, 16'h0000);
		send_item(OP_DIV, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct);
		op_t              op;
		logic [FIELD_W-1:0] ar, ai, br, bi;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (RANDOM_ITEMS) begin
			op = op_t'($urandom_range(3));
			ar = random_part();
			ai = random_part();
			br = random_part();
			bi = random_part();
			if (op == OP_DIV && $urandom_range(19) == 0) begin
				br = '0;
				bi = '0;
			end
			send_item(op, ar, ai, br, bi);
		end
	endtask

	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected beat: re %h im %h st %0d",
						m_tdata[RES_W-1:0], m_tdata[2*RES_W-1:RES_W], m_tuser);
			end else begin
				oldest = pending_results.pop_front();
				if (m_tdata[RES_W-1:0] !== oldest.re ||
						m_tdata[2*RES_W-1:RES_W] !== oldest.im ||
						m_tuser !== oldest.st) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("mismatch: got re %h im %h st %0d, want re %h im %h st %0d",
							m_tdata[RES_W-1:0], m_tdata[2*RES_W-1:RES_W], m_tuser,
							oldest.re, oldest.im, oldest.st);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tuser  = OP_ADD;
		s_tdata  = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		test_add_sub_limits();
		test_multiply_limits();
		test_divide_cases();
		test_random_traffic(0, 0);
		test_random_traffic(64, 0);
		test_random_traffic(0, 64);
		test_random_traffic(28, 28);

		s_tvalid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/cau_pkg.sv
sv/cau_mult.sv
sv/cau_comb.sv
sv/cau_div.sv
sv/cau_sat.sv
sv/complex_arithmetic_unit.sv
sv/cau_checker.sv
bench/testbench.sv
